/* rtl/lane_change_speed_planner_assert.svh */
// Assertion macros shared by the checker.
`ifndef LANE_CHANGE_SPEED_PLANNER_ASSERT_SVH
`define LANE_CHANGE_SPEED_PLANNER_ASSERT_SVH

// Same-cycle implication under clock and active-low reset.
`define LCSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcsp assertion failed");

// Next-cycle implication under clock and active-low reset.
`define LCSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcsp assertion failed");

`endif

/* rtl/lcsp_pkg.sv */
`default_nettype none

package lcsp_pkg;

  localparam int unsigned LANE_COUNT_DEF = 3;
  localparam int unsigned PATH_LEN_DEF   = 50;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned S_W    = 21;
  localparam int unsigned PTS_W  = 6;
  localparam int unsigned D_W    = 13;
  localparam int unsigned V_W    = 16;
  localparam int unsigned LANE_W = 2;
  localparam int unsigned SPD_W  = 14;
  localparam int unsigned GAP_W  = 16;
  localparam int unsigned STEP_W = 10;
  localparam int unsigned LW_W   = 12;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_BEGIN   = 2'd0;
  localparam logic [OP_W-1:0] OP_VEHICLE = 2'd1;
  localparam logic [OP_W-1:0] OP_END     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAP_AHEAD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_BEHIND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_WIDTH  = 3'd4;

  localparam logic [GAP_W-1:0]  GAP_AHEAD_RST   = 16'd7680;
  localparam logic [GAP_W-1:0]  GAP_BEHIND_RST  = 16'd2560;
  localparam logic [STEP_W-1:0] SPEED_STEP_RST  = 10'd115;
  localparam logic [SPD_W-1:0]  SPEED_LIMIT_RST = 14'd12672;
  localparam logic [LW_W-1:0]   LANE_WIDTH_RST  = 12'd1024;
  localparam logic [LANE_W-1:0] LANE_RST        = 2'd1;
  localparam logic [SPD_W-1:0]  SPEED_MAX       = '1;

  localparam int unsigned FLAG_W     = 3;
  localparam int unsigned FLAG_OWN   = 0;
  localparam int unsigned FLAG_LEFT  = 1;
  localparam int unsigned FLAG_RIGHT = 2;

  localparam int unsigned ALU_W  = 32;
  localparam int unsigned MUL_W  = 23;
  localparam int unsigned PROD_W = 2 * MUL_W;

  localparam int unsigned PROJ_DIV    = 50;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + PROJ_DIV - 1) / PROJ_DIV;

  localparam logic [ALU_W-1:0] ROOT_BIT_INIT = ALU_W'(1) << (ALU_W - 2);

  localparam int unsigned DIFF_W = S_W + 2;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

endpackage

`default_nettype wire

/* rtl/lcsp_if.sv */
`default_nettype none

interface lcsp_req_if
  import lcsp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic [S_W-1:0]          ego_s;
  logic [S_W-1:0]          path_end_s;
  logic [PTS_W-1:0]        path_points;
  logic signed [D_W-1:0]   other_d;
  logic signed [V_W-1:0]   other_vx;
  logic signed [V_W-1:0]   other_vy;
  logic [S_W-1:0]          other_s;

  modport source (
    output valid, opcode, ego_s, path_end_s, path_points, other_d, other_vx, other_vy,
           other_s,
    input  ready
  );
  modport sink (
    input  valid, opcode, ego_s, path_end_s, path_points, other_d, other_vx, other_vy,
           other_s,
    output ready
  );
endinterface

interface lcsp_rsp_if
  import lcsp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [LANE_W-1:0] target_lane;
  logic [SPD_W-1:0]  reference_speed;
  logic              blocked_own;
  logic              blocked_left;
  logic              blocked_right;

  modport source (
    output valid, target_lane, reference_speed, blocked_own, blocked_left, blocked_right,
    input  ready
  );
  modport sink (
    input  valid, target_lane, reference_speed, blocked_own, blocked_left, blocked_right,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/lcsp_alu.sv */
`default_nettype none

module lcsp_alu
  import lcsp_pkg::*;
(
  input  alu_req_t            req_i,
  output logic [PROD_W-1:0]   res_o
);

  logic [ALU_W:0] sum;

  always_comb begin
    sum   = '0;
    res_o = '0;
    unique case (req_i.op)
      ALU_ADD: begin
        sum   = {1'b0, req_i.a} + {1'b0, req_i.b};
        res_o = PROD_W'(sum);
      end
      ALU_SUB: begin
        sum   = {1'b0, req_i.a} - {1'b0, req_i.b};
        res_o = PROD_W'(sum);
      end
      ALU_MUL: begin
        res_o = req_i.a[MUL_W-1:0] * req_i.b[MUL_W-1:0];
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/lcsp_lane.sv */
`default_nettype none

module lcsp_lane
  import lcsp_pkg::*;
(
  input  logic signed [D_W-1:0] d_i,
  input  logic [LW_W-1:0]       width_i,
  input  logic [LANE_W-1:0]     lane_i,
  output logic [FLAG_W-1:0]     hit_o
);

  localparam int unsigned BND_W = LW_W + 5;

  logic signed [BND_W-1:0] w_s;
  logic signed [BND_W-1:0] d_s;
  logic signed [BND_W-1:0] lo [FLAG_W];
  logic signed [BND_W-1:0] hi [FLAG_W];
  logic signed [3:0]       k  [FLAG_W];

  always_comb begin
    w_s = $signed({{(BND_W-LW_W){1'b0}}, width_i});
    d_s = BND_W'(d_i);
    k[FLAG_OWN]   = $signed({2'b00, lane_i});
    k[FLAG_LEFT]  = $signed({2'b00, lane_i}) - 4'sd1;
    k[FLAG_RIGHT] = $signed({2'b00, lane_i}) + 4'sd1;
    for (int i = 0; i < FLAG_W; i++) begin
      lo[i]    = BND_W'(w_s * BND_W'(k[i]));
      hi[i]    = lo[i] + w_s;
      hit_o[i] = (d_s > lo[i]) && (d_s < hi[i]);
    end
  end

endmodule

`default_nettype wire

/* rtl/lane_change_speed_planner.sv */
// Highway lane and speed planner. Requests carry an opcode: begin frame (latch the own
// position and path point count, clear the blocked flags), vehicle (fold one nearby car
// into the blocked flags) or end frame (decide lane and reference speed and return one
// response). Begin, end and unused opcodes are handled in the idle state. A vehicle
// request keeps req_i.ready low until the car is folded in, so none is taken before then;
// one shared multiply/add/subtract unit steps through two squares, a 16-step
// integer square root, the projection scale and reciprocal multiply, and the gap
// compare. The end-frame response lands in an output register the cycle after the
// request and is held until rsp_o.ready; a new begin or vehicle request is taken
// meanwhile only while that register is free or being drained. Configuration writes are
// single-cycle and take effect at once.
`default_nettype none

module lane_change_speed_planner
  import lcsp_pkg::*;
#(
  parameter int unsigned LANE_COUNT = LANE_COUNT_DEF,
  parameter int unsigned PATH_LEN   = PATH_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lcsp_req_if.sink              req_i,
  lcsp_rsp_if.source            rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQX   = 4'd1;
  localparam logic [3:0] ST_SQY   = 4'd2;
  localparam logic [3:0] ST_SUM   = 4'd3;
  localparam logic [3:0] ST_ROOT  = 4'd4;
  localparam logic [3:0] ST_SCALE = 4'd5;
  localparam logic [3:0] ST_RECIP = 4'd6;
  localparam logic [3:0] ST_PROJ  = 4'd7;
  localparam logic [3:0] ST_DIFF  = 4'd8;
  localparam logic [3:0] ST_FLAG  = 4'd9;

  logic [3:0] state_q, state_d;

  logic [GAP_W-1:0]  gap_ahead_q, gap_behind_q;
  logic [STEP_W-1:0] speed_step_q;
  logic [SPD_W-1:0]  speed_limit_q;
  logic [LW_W-1:0]   lane_width_q;

  logic [LANE_W-1:0] lane_q, lane_d;
  logic [SPD_W-1:0]  speed_q, speed_d;
  logic [S_W-1:0]    fpos_q, fpos_d;
  logic [PTS_W-1:0]  fpts_q, fpts_d;
  logic [FLAG_W-1:0] flags_q, flags_d;

  logic [V_W:0]          ax_q, ax_d, ay_q, ay_d;
  logic signed [D_W-1:0] d_q, d_d;
  logic [S_W-1:0]        s_q, s_d;
  logic [ALU_W-1:0]      v_q, v_d, t_q, t_d, root_q, root_d, bit_q, bit_d;

  logic              out_valid_q, out_valid_d;
  logic [LANE_W-1:0] out_lane_q, out_lane_d;
  logic [SPD_W-1:0]  out_speed_q, out_speed_d;
  logic [FLAG_W-1:0] out_flags_q, out_flags_d;

  alu_req_t         alu_req;
  logic [PROD_W-1:0] alu_res;
  logic [FLAG_W-1:0] lane_hit;

  logic              accept;
  logic [V_W:0]      vx_ext, vy_ext;
  logic [PTS_W-1:0]  pts_clamp;
  logic [SPD_W-1:0]  dec_speed, inc_speed;
  logic [SPD_W:0]    inc_sum;
  logic [DIFF_W-1:0] diff, diff_neg;
  logic              ahead, behind;

  lcsp_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  lcsp_lane u_lane (
    .d_i     (d_q),
    .width_i (lane_width_q),
    .lane_i  (lane_q),
    .hit_o   (lane_hit)
  );

  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.target_lane     = out_lane_q;
  assign rsp_o.reference_speed = out_speed_q;
  assign rsp_o.blocked_own     = out_flags_q[FLAG_OWN];
  assign rsp_o.blocked_left    = out_flags_q[FLAG_LEFT];
  assign rsp_o.blocked_right   = out_flags_q[FLAG_RIGHT];

  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    unique case (state_q)
      ST_SQX: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = ALU_W'(ax_q);
        alu_req.b  = ALU_W'(ax_q);
      end
      ST_SQY: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = ALU_W'(ay_q);
        alu_req.b  = ALU_W'(ay_q);
      end
      ST_SUM: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = v_q;
        alu_req.b  = t_q;
      end
      ST_ROOT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = v_q;
        alu_req.b  = root_q | bit_q;
      end
      ST_SCALE: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = ALU_W'(fpts_q);
        alu_req.b  = root_q;
      end
      ST_RECIP: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = t_q;
        alu_req.b  = ALU_W'(RECIP);
      end
      ST_PROJ: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = ALU_W'(s_q);
        alu_req.b  = t_q;
      end
      ST_DIFF: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = v_q;
        alu_req.b  = ALU_W'(fpos_q);
      end
      default: begin
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  always_comb begin
    vx_ext    = {req_i.other_vx[V_W-1], req_i.other_vx};
    vy_ext    = {req_i.other_vy[V_W-1], req_i.other_vy};
    pts_clamp = (req_i.path_points > PTS_W'(PATH_LEN)) ? PTS_W'(PATH_LEN) : req_i.path_points;

    dec_speed = (speed_q > SPD_W'(speed_step_q)) ? speed_q - SPD_W'(speed_step_q) : '0;
    inc_sum   = {1'b0, speed_q} + (SPD_W+1)'(speed_step_q);
    inc_speed = inc_sum[SPD_W] ? SPEED_MAX : inc_sum[SPD_W-1:0];

    diff     = v_q[DIFF_W-1:0];
    diff_neg = '0 - diff;
    ahead    = !diff[DIFF_W-1] && (diff != '0) && (diff < DIFF_W'(gap_ahead_q));
    behind   = diff[DIFF_W-1] && (diff_neg < DIFF_W'(gap_behind_q));
  end

  always_comb begin
    state_d     = state_q;
    lane_d      = lane_q;
    speed_d     = speed_q;
    fpos_d      = fpos_q;
    fpts_d      = fpts_q;
    flags_d     = flags_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    d_d         = d_q;
    s_d         = s_q;
    v_d         = v_q;
    t_d         = t_q;
    root_d      = root_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_lane_d  = out_lane_q;
    out_speed_d = out_speed_q;
    out_flags_d = out_flags_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.opcode)
            OP_BEGIN: begin
              fpts_d  = pts_clamp;
              fpos_d  = (pts_clamp != '0) ? req_i.path_end_s : req_i.ego_s;
              flags_d = '0;
            end
            OP_VEHICLE: begin
              ax_d    = vx_ext[V_W] ? (~vx_ext + 1'b1) : vx_ext;
              ay_d    = vy_ext[V_W] ? (~vy_ext + 1'b1) : vy_ext;
              d_d     = req_i.other_d;
              s_d     = req_i.other_s;
              state_d = ST_SQX;
            end
            OP_END: begin
              if (flags_q[FLAG_OWN]) begin
                speed_d = dec_speed;
                if (!flags_q[FLAG_LEFT] && (lane_q != '0)) begin
                  lane_d = lane_q - 1'b1;
                end else if (!flags_q[FLAG_RIGHT] && (lane_q < LANE_W'(LANE_COUNT - 1))) begin
                  lane_d = lane_q + 1'b1;
                end
              end else if (speed_q < speed_limit_q) begin
                speed_d = inc_speed;
              end
              out_valid_d = 1'b1;
              out_lane_d  = lane_d;
              out_speed_d = speed_d;
              out_flags_d = flags_q;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SQX: begin
        v_d     = alu_res[ALU_W-1:0];
        state_d = ST_SQY;
      end
      ST_SQY: begin
        t_d     = alu_res[ALU_W-1:0];
        state_d = ST_SUM;
      end
      ST_SUM: begin
        v_d     = alu_res[ALU_W-1:0];
        root_d  = '0;
        bit_d   = ROOT_BIT_INIT;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (!alu_res[ALU_W]) begin
          v_d    = alu_res[ALU_W-1:0];
          root_d = (root_q >> 1) | bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        t_d     = alu_res[ALU_W-1:0];
        state_d = ST_RECIP;
      end
      ST_RECIP: begin
        t_d     = ALU_W'(alu_res[PROD_W-1:RECIP_SHIFT]);
        state_d = ST_PROJ;
      end
      ST_PROJ: begin
        v_d     = alu_res[ALU_W-1:0];
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        v_d     = alu_res[ALU_W-1:0];
        state_d = ST_FLAG;
      end
      ST_FLAG: begin
        flags_d[FLAG_OWN]   = flags_q[FLAG_OWN] | (ahead & lane_hit[FLAG_OWN]);
        flags_d[FLAG_LEFT]  = flags_q[FLAG_LEFT] | ((ahead | behind) & lane_hit[FLAG_LEFT]);
        flags_d[FLAG_RIGHT] = flags_q[FLAG_RIGHT] | ((ahead | behind) & lane_hit[FLAG_RIGHT]);
        state_d             = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lane_q      <= LANE_RST;
      speed_q     <= '0;
      fpos_q      <= '0;
      fpts_q      <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lane_q      <= lane_d;
      speed_q     <= speed_d;
      fpos_q      <= fpos_d;
      fpts_q      <= fpts_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ahead_q   <= GAP_AHEAD_RST;
      gap_behind_q  <= GAP_BEHIND_RST;
      speed_step_q  <= SPEED_STEP_RST;
      speed_limit_q <= SPEED_LIMIT_RST;
      lane_width_q  <= LANE_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAP_AHEAD:   gap_ahead_q   <= cfg_data_i[GAP_W-1:0];
        CFG_GAP_BEHIND:  gap_behind_q  <= cfg_data_i[GAP_W-1:0];
        CFG_SPEED_STEP:  speed_step_q  <= cfg_data_i[STEP_W-1:0];
        CFG_SPEED_LIMIT: speed_limit_q <= cfg_data_i[SPD_W-1:0];
        CFG_LANE_WIDTH:  lane_width_q  <= cfg_data_i[LW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q        <= ax_d;
    ay_q        <= ay_d;
    d_q         <= d_d;
    s_q         <= s_d;
    v_q         <= v_d;
    t_q         <= t_d;
    root_q      <= root_d;
    bit_q       <= bit_d;
    out_lane_q  <= out_lane_d;
    out_speed_q <= out_speed_d;
    out_flags_q <= out_flags_d;
  end

endmodule

`default_nettype wire

/* rtl/lcsp_checker.sv */
`default_nettype none

`include "lane_change_speed_planner_assert.svh"

module lcsp_checker
  import lcsp_pkg::*;
#(
  parameter int unsigned LANE_COUNT = LANE_COUNT_DEF
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              req_valid_i,
  input wire logic              req_ready_i,
  input wire logic [OP_W-1:0]   req_opcode_i,
  input wire logic              rsp_valid_i,
  input wire logic              rsp_ready_i,
  input wire logic [LANE_W-1:0] rsp_lane_i,
  input wire logic [SPD_W-1:0]  rsp_speed_i
);

  `LCSP_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_lane_i) && $stable(rsp_speed_i))

  `LCSP_ASSERT_NXT(a_end_gives_rsp, clk_i, rst_ni, req_valid_i && req_ready_i && (req_opcode_i == OP_END), rsp_valid_i)

  `LCSP_ASSERT_NXT(a_vehicle_busy, clk_i, rst_ni, req_valid_i && req_ready_i && (req_opcode_i == OP_VEHICLE), !req_ready_i)

  `LCSP_ASSERT_IMP(a_lane_range, clk_i, rst_ni, rsp_valid_i, rsp_lane_i <= LANE_W'(LANE_COUNT - 1))

endmodule

bind lane_change_speed_planner lcsp_checker #(
  .LANE_COUNT (LANE_COUNT)
) u_lcsp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_opcode_i (req_i.opcode),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_lane_i   (rsp_o.target_lane),
  .rsp_speed_i  (rsp_o.reference_speed)
);

`default_nettype wire

/* sim/lane_change_speed_planner_checker.sv */
module lane_change_speed_planner_checker
  import lcsp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lcsp_req_if                   req_i,
  lcsp_rsp_if                   rsp_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           mismatches_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic [SPD_W-1:0]  speed;
    logic              own;
    logic              left;
    logic              right;
  } lane_plan_t;

  logic [GAP_W-1:0]  gap_ahead;
  logic [GAP_W-1:0]  gap_behind;
  logic [STEP_W-1:0] speed_step;
  logic [SPD_W-1:0]  speed_limit;
  logic [LW_W-1:0]   lane_width;

  logic [LANE_W-1:0] lane;
  logic [SPD_W-1:0]  speed;
  logic [S_W-1:0]    frame_pos;
  logic [PTS_W-1:0]  frame_pts;
  logic [FLAG_W-1:0] near_flags;

  lane_plan_t lane_plans[$];
  lane_plan_t head;

  function automatic logic [ALU_W-1:0] int_sqrt(input logic [ALU_W-1:0] v);
    logic [ALU_W-1:0] rem;
    logic [ALU_W-1:0] root;
    logic [ALU_W-1:0] probe;
    rem = v;
    root = '0;
    probe = ALU_W'(1) << (ALU_W - 2);
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic bit in_lane_span(input int d, input int idx);
    int w;
    w = int'(lane_width);
    return d > w * idx && d < w * (idx + 1);
  endfunction

  task automatic fold_vehicle();
    int               d;
    int               vx;
    int               vy;
    int               cur;
    logic [ALU_W-1:0] mag;
    logic [ALU_W-1:0] proj;
    logic [ALU_W-1:0] pos;
    bit               ahead;
    bit               behind;
    d = int'(req_i.other_d);
    vx = int'(req_i.other_vx);
    vy = int'(req_i.other_vy);
    mag = int_sqrt(ALU_W'(vx * vx) + ALU_W'(vy * vy));
    pos = ALU_W'(frame_pos);
    proj = ALU_W'(req_i.other_s) + (ALU_W'(frame_pts) * mag) / ALU_W'(50);
    ahead = proj > pos && proj - pos < ALU_W'(gap_ahead);
    behind = proj < pos && pos - proj < ALU_W'(gap_behind);
    cur = int'(lane);
    if (ahead && in_lane_span(d, cur)) near_flags[FLAG_OWN] = 1'b1;
    if ((ahead || behind) && in_lane_span(d, cur - 1)) near_flags[FLAG_LEFT] = 1'b1;
    if ((ahead || behind) && in_lane_span(d, cur + 1)) near_flags[FLAG_RIGHT] = 1'b1;
  endtask

  task automatic decide_lane();
    int         next_speed;
    lane_plan_t plan;
    if (near_flags[FLAG_OWN]) begin
      speed = speed > speed_step ? speed - speed_step : '0;
      if (!near_flags[FLAG_LEFT] && lane >= 2'd1) begin
        lane = lane - 2'd1;
      end else if (!near_flags[FLAG_RIGHT] && int'(lane) + 1 <= int'(LANE_COUNT_DEF) - 1) begin
        lane = lane + 2'd1;
      end
    end else if (speed < speed_limit) begin
      next_speed = int'(speed) + int'(speed_step);
      speed = next_speed > int'(SPEED_MAX) ? SPEED_MAX : SPD_W'(next_speed);
    end
    plan = '{lane, speed, near_flags[FLAG_OWN], near_flags[FLAG_LEFT],
             near_flags[FLAG_RIGHT]};
    lane_plans = {lane_plans, plan};
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches_o++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ahead = GAP_AHEAD_RST;
      gap_behind = GAP_BEHIND_RST;
      speed_step = SPEED_STEP_RST;
      speed_limit = SPEED_LIMIT_RST;
      lane_width = LANE_WIDTH_RST;
      lane = LANE_RST;
      speed = '0;
      frame_pos = '0;
      frame_pts = '0;
      near_flags = '0;
      lane_plans.delete();
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GAP_AHEAD:   gap_ahead = cfg_data_i;
          CFG_GAP_BEHIND:  gap_behind = cfg_data_i;
          CFG_SPEED_STEP:  speed_step = cfg_data_i[STEP_W-1:0];
          CFG_SPEED_LIMIT: speed_limit = cfg_data_i[SPD_W-1:0];
          CFG_LANE_WIDTH:  lane_width = cfg_data_i[LW_W-1:0];
          default: ;
        endcase
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (lane_plans.size() == 0) begin
          mismatches_o++;
          $display("%0t unexpected response: expected none, actual lane %0d speed %0d",
                   $time, rsp_i.target_lane, rsp_i.reference_speed);
        end else begin
          head = lane_plans.pop_front();
          check_field("target_lane", head.lane, rsp_i.target_lane);
          check_field("reference_speed", head.speed, rsp_i.reference_speed);
          check_field("blocked_own", head.own, rsp_i.blocked_own);
          check_field("blocked_left", head.left, rsp_i.blocked_left);
          check_field("blocked_right", head.right, rsp_i.blocked_right);
        end
      end
      if (req_i.valid && req_i.ready) begin
        case (req_i.opcode)
          OP_BEGIN: begin
            frame_pts = req_i.path_points > PTS_W'(PATH_LEN_DEF) ?
                        PTS_W'(PATH_LEN_DEF) : req_i.path_points;
            frame_pos = req_i.path_points != '0 ? req_i.path_end_s : req_i.ego_s;
            near_flags = '0;
          end
          OP_VEHICLE: fold_vehicle();
          OP_END:     decide_lane();
          default: ;
        endcase
      end
      pending_o = lane_plans.size();
    end
  end

endmodule

/* sim/lane_change_speed_planner_tb.sv */
module lane_change_speed_planner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcsp_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int S_MAX = (1 << S_W) - 1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           mismatches;
  int unsigned           plans_pending;

  bit burst;
  int sent_items;
  int frame_pos;
  int frame_pts;
  int gap_a;
  int gap_b;
  int lane_w;

  lcsp_req_if req_if ();
  lcsp_rsp_if rsp_if ();

  lane_change_speed_planner u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  lane_change_speed_planner_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (plans_pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic int rand_d();
    return int'($urandom_range(8191)) - 4096;
  endfunction

  function automatic int rand_v();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int rand_s();
    return int'($urandom_range(S_MAX));
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input int ego, input int pend,
                              input int pts, input int d, input int vx, input int vy,
                              input int s);
    int gap;
    gap = burst ? 0 : int'($urandom_range(3));
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.ego_s       <= S_W'(ego);
    req_if.path_end_s  <= S_W'(pend);
    req_if.path_points <= PTS_W'(pts);
    req_if.other_d     <= D_W'(d);
    req_if.other_vx    <= V_W'(vx);
    req_if.other_vy    <= V_W'(vy);
    req_if.other_s     <= S_W'(s);
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (op != OP_NONE) sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_vehicle();
    int d;
    int vx;
    int vy;
    int s;
    int shift;
    int pick;
    if ($urandom_range(99) < 75) begin
      d = (int'($urandom_range(4)) - 1) * lane_w + int'($urandom_range(lane_w));
      if (d > 4095) d = 4095;
      if (d < -4096) d = -4096;
    end else begin
      d = rand_d();
    end
    pick = int'($urandom_range(99));
    if (pick < 45) begin
      vx = int'($urandom_range(4000)) - 2000;
      vy = int'($urandom_range(4000)) - 2000;
    end else if (pick < 75) begin
      vx = rand_v();
      vy = rand_v();
    end else begin
      vx = 0;
      vy = 0;
    end
    shift = int'($floor(real'(frame_pts) *
                        $sqrt(real'(longint'(vx) * vx + longint'(vy) * vy)) / 50.0));
    if ($urandom_range(9) < 7) begin
      s = frame_pos - shift - gap_b - 256 + int'($urandom_range(gap_a + gap_b + 512));
      if (s < 0) s = 0;
      if (s > S_MAX) s = S_MAX;
    end else begin
      s = rand_s();
    end
    send_request(OP_VEHICLE, rand_s(), rand_s(), int'($urandom_range(63)), d, vx, vy, s);
  endtask

  task automatic send_frame();
    int pts;
    int ego;
    int pend;
    int pick;
    burst = ($urandom_range(4) == 0);
    if ($urandom_range(99) >= 8) begin
      pick = int'($urandom_range(99));
      if (pick < 15) pts = 0;
      else if (pick < 85) pts = int'($urandom_range(50, 1));
      else pts = int'($urandom_range(63, 51));
      ego = rand_s();
      pend = rand_s();
      send_request(OP_BEGIN, ego, pend, pts, rand_d(), rand_v(), rand_v(), rand_s());
      frame_pts = pts > PATH_LEN_DEF ? PATH_LEN_DEF : pts;
      frame_pos = pts > 0 ? pend : ego;
    end
    repeat ($urandom_range(6)) send_vehicle();
    if ($urandom_range(99) >= 5) begin
      send_request(OP_END, rand_s(), rand_s(), int'($urandom_range(63)), rand_d(), rand_v(),
                   rand_v(), rand_s());
    end
    if ($urandom_range(9) == 0) begin
      send_request(OP_END, rand_s(), rand_s(), int'($urandom_range(63)), rand_d(), rand_v(),
                   rand_v(), rand_s());
    end
    if ($urandom_range(99) < 6) begin
      send_request(OP_W'($urandom_range(3)), rand_s(), rand_s(), int'($urandom_range(63)),
                   rand_d(), rand_v(), rand_v(), rand_s());
    end
  endtask

  task automatic run_phase(input int count);
    int start;
    start = sent_items;
    while (sent_items - start < count) send_frame();
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    wait (plans_pending == 0);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(negedge clk_i);
  endtask

  task automatic set_config(input int ga, input int gb, input int step, input int lim,
                            input int lw);
    write_reg(CFG_GAP_AHEAD, ga);
    write_reg(CFG_GAP_BEHIND, gb);
    write_reg(CFG_SPEED_STEP, step);
    write_reg(CFG_SPEED_LIMIT, lim);
    write_reg(CFG_LANE_WIDTH, lw);
    cfg_we <= 1'b0;
    gap_a = ga;
    gap_b = gb;
    lane_w = lw;
  endtask

  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = burst ? 0 : int'($urandom_range(3));
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    req_if.valid       = 1'b0;
    req_if.opcode      = OP_BEGIN;
    req_if.ego_s       = '0;
    req_if.path_end_s  = '0;
    req_if.path_points = '0;
    req_if.other_d     = '0;
    req_if.other_vx    = '0;
    req_if.other_vy    = '0;
    req_if.other_s     = '0;
    cfg_we     = 1'b0;
    cfg_idx    = CFG_GAP_AHEAD;
    cfg_data   = '0;
    rst_ni     = 1'b0;
    burst      = 1'b0;
    sent_items = 0;
    frame_pos  = 0;
    frame_pts  = 0;
    gap_a      = int'(GAP_AHEAD_RST);
    gap_b      = int'(GAP_BEHIND_RST);
    lane_w     = int'(LANE_WIDTH_RST);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // vehicle before any frame, unused opcode, repeated decisions
    send_request(OP_VEHICLE, 0, 0, 0, 1536, 0, 0, 100);
    send_request(OP_NONE, S_MAX, S_MAX, 63, -1, -1, -1, S_MAX);
    send_request(OP_END, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_END, 0, 0, 0, 0, 0, 0, 0);
    // equal position, extreme velocities and positions
    send_request(OP_BEGIN, S_MAX, 0, 0, 0, 0, 0, 0);
    send_request(OP_VEHICLE, 0, 0, 0, 1536, 0, 0, S_MAX);
    send_request(OP_VEHICLE, 0, 0, 0, -4096, -32768, -32768, 0);
    send_request(OP_END, 0, 0, 0, 0, 0, 0, 0);
    // clamped path points, behind on the left, ahead in own lane
    send_request(OP_BEGIN, 0, 1000, 63, 0, 0, 0, 0);
    send_request(OP_VEHICLE, 0, 0, 0, 4095, 32767, 32767, 0);
    send_request(OP_VEHICLE, 0, 0, 0, 512, 0, 0, 0);
    send_request(OP_VEHICLE, 0, 0, 0, 1500, 300, 400, 900);
    send_request(OP_END, 0, 0, 0, 0, 0, 0, 0);
    // off-road right lane from the last lane
    send_request(OP_BEGIN, 5000, 0, 1, 0, 0, 0, 0);
    send_request(OP_VEHICLE, 0, 0, 0, 3500, 0, 0, 100);
    send_request(OP_VEHICLE, 0, 0, 0, 2500, 0, 0, 10);
    send_request(OP_END, 0, 0, 0, 0, 0, 0, 0);
    // lane borders and gap edges
    send_request(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_VEHICLE, 0, 0, 0, 1025, 0, 0, 1);
    send_request(OP_VEHICLE, 0, 0, 0, 1024, 0, 0, 1);
    send_request(OP_VEHICLE, 0, 0, 0, 2049, 0, 0, 7679);
    send_request(OP_VEHICLE, 0, 0, 0, 1000, 0, 0, 7680);
    send_request(OP_END, 0, 0, 0, 0, 0, 0, 0);
    // off-road left lane from lane zero
    send_request(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_VEHICLE, 0, 0, 0, 1, 0, 0, 5);
    send_request(OP_VEHICLE, 0, 0, 0, -1, 0, 0, 5);
    send_request(OP_END, 0, 0, 0, 0, 0, 0, 0);
    frame_pos = 0;
    frame_pts = 0;

    run_phase(80);
    settle();
    set_config(0, 65535, 1023, 16383, 4095);
    run_phase(60);
    settle();
    set_config(65535, 0, 1023, 0, 1);
    run_phase(50);
    settle();
    set_config(65535, 65535, 700, 15360, 2);
    run_phase(70);
    settle();
    set_config(20000, 8000, 300, 9000, 1500);
    run_phase(100);
    settle();
    set_config(7680, 2560, 0, 12672, 0);
    run_phase(40);
    settle();
    set_config(7680, 2560, 1023, 12672, 1024);
    run_phase(60);
    settle();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/lcsp_pkg.sv
rtl/lcsp_if.sv
rtl/lcsp_alu.sv
rtl/lcsp_lane.sv
rtl/lane_change_speed_planner.sv
rtl/lcsp_checker.sv
sim/lane_change_speed_planner_checker.sv
sim/lane_change_speed_planner_tb.sv
